@@ rtl/core/pa_pkg.sv @@
package pa_pkg;

  localparam int ARCHIVE_DEPTH_DEF = 64;
  localparam int MAX_OBJ = 4;
  localparam int OBJ_W = 32;
  localparam int TAG_W = 16;
  localparam int RIDX_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int COUNT_MAX = 127;

  localparam logic CFG_OBJ_COUNT = 1'b0;
  localparam logic CFG_MAX_MASK = 1'b1;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [MAX_OBJ-1:0][OBJ_W-1:0] pa_objs_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    pa_objs_t obj;
  } pa_entry_t;

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_last;
    logic rd_user;
    logic move;
    logic inc;
    logic rst_scan;
    logic mark_dom;
    logic fin_offer;
    logic fin_read;
  } pa_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic cand_dom;
    logic dominated;
    logic out_free;
  } pa_stat_t;

  // Point a dominates point b: nowhere worse and somewhere strictly better.
  function automatic logic dominates(input pa_objs_t a, input pa_objs_t b,
                                     input logic [2:0] cnt, input logic [3:0] mask);
    logic better;
    logic worse;
    logic gt;
    logic lt;
    logic [2:0] n;
    better = 1'b0;
    worse = 1'b0;
    if (cnt == 3'd0) begin
      n = 3'd1;
    end else if (cnt > 3'(MAX_OBJ)) begin
      n = 3'(MAX_OBJ);
    end else begin
      n = cnt;
    end
    for (int k = 0; k < MAX_OBJ; k++) begin
      gt = $signed(a[k]) > $signed(b[k]);
      lt = $signed(a[k]) < $signed(b[k]);
      if (k < int'(n)) begin
        if (mask[k]) begin
          better = better | gt;
          worse = worse | lt;
        end else begin
          better = better | lt;
          worse = worse | gt;
        end
      end
    end
    return better & ~worse;
  endfunction

endpackage

@@ rtl/core/pa_ctrl.sv @@
module pa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             op,
  output logic             in_stall,
  input  pa_pkg::pa_stat_t stat,
  output pa_pkg::pa_cmd_t  cmd
);
  import pa_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_P1_RD   = 3'd1;
  localparam logic [2:0] S_P1_CMP  = 3'd2;
  localparam logic [2:0] S_P1_MOVE = 3'd3;
  localparam logic [2:0] S_P2_RD   = 3'd4;
  localparam logic [2:0] S_P2_CMP  = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;
  localparam logic [2:0] S_RD_WAIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (op == OP_READ) begin
            cmd.rd_user = 1'b1;
            state_next = S_RD_WAIT;
          end else begin
            state_next = S_P1_RD;
          end
        end
      end
      S_P1_RD: begin
        if (stat.scan_end) begin
          cmd.rst_scan = 1'b1;
          state_next = S_P2_RD;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next = S_P1_CMP;
        end
      end
      S_P1_CMP: begin
        if (stat.cand_dom) begin
          cmd.rd_last = 1'b1;
          state_next = S_P1_MOVE;
        end else begin
          cmd.inc = 1'b1;
          state_next = S_P1_RD;
        end
      end
      S_P1_MOVE: begin
        // The moved entry lands in the current slot, which is then tested again.
        cmd.move = 1'b1;
        state_next = S_P1_RD;
      end
      S_P2_RD: begin
        if (stat.scan_end || stat.dominated) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next = S_P2_CMP;
        end
      end
      S_P2_CMP: begin
        cmd.mark_dom = 1'b1;
        cmd.inc = 1'b1;
        state_next = S_P2_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin_offer = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        if (stat.out_free) begin
          cmd.fin_read = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/pa_dp.sv @@
module pa_dp #(
  parameter int ARCHIVE_DEPTH = pa_pkg::ARCHIVE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pa_pkg::pa_cmd_t                      cmd,
  output pa_pkg::pa_stat_t                     stat,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_index,
  input  logic [3:0]                           cfg_data,
  input  logic [pa_pkg::TAG_W-1:0]             solution_tag,
  input  logic signed [pa_pkg::OBJ_W-1:0]      obj_0,
  input  logic signed [pa_pkg::OBJ_W-1:0]      obj_1,
  input  logic signed [pa_pkg::OBJ_W-1:0]      obj_2,
  input  logic signed [pa_pkg::OBJ_W-1:0]      obj_3,
  input  logic [pa_pkg::RIDX_W-1:0]            read_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 inserted,
  output logic [pa_pkg::CNT_OUT_W-1:0]         removed_count,
  output logic                                 full_drop,
  output logic [pa_pkg::CNT_OUT_W-1:0]         entry_count,
  output logic                                 entry_valid,
  output logic [pa_pkg::TAG_W-1:0]             entry_tag,
  output logic signed [pa_pkg::OBJ_W-1:0]      entry_obj_0,
  output logic signed [pa_pkg::OBJ_W-1:0]      entry_obj_1,
  output logic signed [pa_pkg::OBJ_W-1:0]      entry_obj_2,
  output logic signed [pa_pkg::OBJ_W-1:0]      entry_obj_3
);
  import pa_pkg::*;

  localparam int AW = $clog2(ARCHIVE_DEPTH);
  localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
  localparam int SW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  pa_entry_t mem [ARCHIVE_DEPTH];
  pa_entry_t rdata;
  pa_entry_t cand;
  pa_entry_t wdata;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic we;
  logic re;

  logic [RIDX_W-1:0] idx_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] scan_i;
  logic [CW-1:0] removed;
  logic [CW-1:0] last;
  logic dominated;
  logic [2:0] obj_count;
  logic [3:0] max_mask;
  logic room;
  logic do_insert;
  logic idx_ok;
  logic [RIDX_W+AW-1:0] ridx_ext;
  logic [RIDX_W+CW-1:0] idx_cmp;
  logic [RIDX_W+CW-1:0] cnt_cmp;
  logic [SW-1:0] rem_sat;
  logic [SW-1:0] cnt_sat;

  function automatic logic [CNT_OUT_W-1:0] sat(input logic [SW-1:0] v);
    return (v > SW'(COUNT_MAX)) ? CNT_OUT_W'(COUNT_MAX) : v[CNT_OUT_W-1:0];
  endfunction

  assign last = count - 1'b1;
  assign ridx_ext = (RIDX_W + AW)'(read_index);
  assign room = (count < CW'(ARCHIVE_DEPTH));
  assign do_insert = cmd.fin_offer && !dominated && room;
  assign idx_cmp = (RIDX_W + CW)'(idx_q);
  assign cnt_cmp = (RIDX_W + CW)'(count);
  assign idx_ok = idx_cmp < cnt_cmp;

  always_comb begin
    re = cmd.rd_scan | cmd.rd_last | cmd.rd_user;
    if (cmd.rd_last) begin
      raddr = last[AW-1:0];
    end else if (cmd.rd_user) begin
      raddr = ridx_ext[AW-1:0];
    end else begin
      raddr = scan_i[AW-1:0];
    end
    we = cmd.move | do_insert;
    if (cmd.move) begin
      waddr = scan_i[AW-1:0];
      wdata = rdata;
    end else begin
      waddr = count[AW-1:0];
      wdata = cand;
    end
    count_next = count;
    if (cmd.move) begin
      count_next = last;
    end else if (do_insert) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign stat.scan_end = (scan_i >= count);
  assign stat.cand_dom = dominates(cand.obj, rdata.obj, obj_count, max_mask);
  assign stat.dominated = dominated;
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_count <= 3'd2;
      max_mask <= 4'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OBJ_COUNT) begin
        obj_count <= cfg_data[2:0];
      end else begin
        max_mask <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand.tag <= solution_tag;
      cand.obj <= {obj_3, obj_2, obj_1, obj_0};
      idx_q <= read_index;
      scan_i <= '0;
      removed <= '0;
      dominated <= 1'b0;
    end else begin
      if (cmd.rst_scan) begin
        scan_i <= '0;
      end else if (cmd.inc) begin
        scan_i <= scan_i + 1'b1;
      end
      if (cmd.move) begin
        removed <= removed + 1'b1;
      end
      if (cmd.mark_dom && dominates(rdata.obj, cand.obj, obj_count, max_mask)) begin
        dominated <= 1'b1;
      end
    end
  end

  assign rem_sat = SW'(removed);
  assign cnt_sat = SW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_offer || cmd.fin_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_offer) begin
      inserted <= !dominated && room;
      full_drop <= !dominated && !room;
      removed_count <= sat(rem_sat);
      entry_count <= sat(cnt_sat);
      entry_valid <= 1'b0;
      entry_tag <= '0;
      entry_obj_0 <= '0;
      entry_obj_1 <= '0;
      entry_obj_2 <= '0;
      entry_obj_3 <= '0;
    end else if (cmd.fin_read) begin
      inserted <= 1'b0;
      full_drop <= 1'b0;
      removed_count <= '0;
      entry_count <= sat(cnt_sat);
      entry_valid <= idx_ok;
      entry_tag <= idx_ok ? rdata.tag : '0;
      entry_obj_0 <= idx_ok ? rdata.obj[0] : '0;
      entry_obj_1 <= idx_ok ? rdata.obj[1] : '0;
      entry_obj_2 <= idx_ok ? rdata.obj[2] : '0;
      entry_obj_3 <= idx_ok ? rdata.obj[3] : '0;
    end
  end

endmodule

@@ rtl/core/pareto_archive_update.sv @@
// Bounded Pareto archive held in one single-port memory with a registered read.
// An offer first sweeps the archive to remove points the candidate dominates:
// each entry is read and compared; on a removal the last entry is read and
// moved into the freed slot, which is then tested again. A second sweep tests
// whether any stored point dominates the candidate, stopping at the first hit;
// a final state appends or drops the candidate once the output register is free.
// A read fetches the requested entry and returns it once the output register
// is free. One item is in work at a time; the next can be accepted while a
// finished result still waits in the output register.
module pareto_archive_update #(
  parameter int ARCHIVE_DEPTH = pa_pkg::ARCHIVE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [3:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [pa_pkg::TAG_W-1:0]         solution_tag,
  input  logic signed [pa_pkg::OBJ_W-1:0]  obj_0,
  input  logic signed [pa_pkg::OBJ_W-1:0]  obj_1,
  input  logic signed [pa_pkg::OBJ_W-1:0]  obj_2,
  input  logic signed [pa_pkg::OBJ_W-1:0]  obj_3,
  input  logic [pa_pkg::RIDX_W-1:0]        read_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             inserted,
  output logic [pa_pkg::CNT_OUT_W-1:0]     removed_count,
  output logic                             full_drop,
  output logic [pa_pkg::CNT_OUT_W-1:0]     entry_count,
  output logic                             entry_valid,
  output logic [pa_pkg::TAG_W-1:0]         entry_tag,
  output logic signed [pa_pkg::OBJ_W-1:0]  entry_obj_0,
  output logic signed [pa_pkg::OBJ_W-1:0]  entry_obj_1,
  output logic signed [pa_pkg::OBJ_W-1:0]  entry_obj_2,
  output logic signed [pa_pkg::OBJ_W-1:0]  entry_obj_3
);
  import pa_pkg::*;

  pa_cmd_t cmd;
  pa_stat_t stat;

  assign cfg_ready = 1'b1;

  pa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pa_dp #(
    .ARCHIVE_DEPTH (ARCHIVE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .solution_tag  (solution_tag),
    .obj_0         (obj_0),
    .obj_1         (obj_1),
    .obj_2         (obj_2),
    .obj_3         (obj_3),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .inserted      (inserted),
    .removed_count (removed_count),
    .full_drop     (full_drop),
    .entry_count   (entry_count),
    .entry_valid   (entry_valid),
    .entry_tag     (entry_tag),
    .entry_obj_0   (entry_obj_0),
    .entry_obj_1   (entry_obj_1),
    .entry_obj_2   (entry_obj_2),
    .entry_obj_3   (entry_obj_3)
  );

  a_ins_xor_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(inserted && full_drop))
    else $error("inserted and full_drop both set");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |-> (!inserted && !full_drop && removed_count == '0))
    else $error("read beat carries offer flags");

  a_idle_no_move: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(cmd.move || cmd.rd_scan || cmd.fin_offer))
    else $error("datapath command issued while idle");

  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_offer || cmd.fin_read) |=> !(cmd.fin_offer || cmd.fin_read))
    else $error("two results finished back to back");

endmodule
